>>> rtl/core/assert_macros.svh
// assertion macros shared by the hot column vote rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property under clock and reset
`define THCV_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define THCV_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  `THCV_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

// next-cycle implication
`define THCV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  `THCV_ASSERT(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

>>> rtl/core/thcv_pkg.sv
// shared constants, config codes and controller/datapath structs
// no dependencies; used by every other file of the block but assert_macros.svh
`timescale 1ns / 1ps

package thcv_pkg;

  localparam int THCV_COLS       = 8;
  localparam int THCV_MAX_WINDOW = 16;

  // field widths
  localparam int IDX_W   = 6;
  localparam int LOW_W   = 8;
  localparam int HIGH_W  = 4;
  localparam int RAW_W   = 12;
  localparam int SUM_W   = 16;
  localparam int TGT_W   = 4;
  localparam int PEAK_W  = 15;
  localparam int PROD_W  = 29;

  // config port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int WLEN_W     = 5;
  localparam int COEFF_W    = 16;
  localparam int HOT_W      = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT_CQ8 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOT_LIMIT   = 2'd2;

  localparam logic [WLEN_W-1:0]  WLEN_RST  = 5'd5;
  localparam logic [COEFF_W-1:0] COEFF_RST = 16'd256;
  localparam logic [HOT_W-1:0]   HOT_RST   = 11'd160;

  localparam logic [TGT_W-1:0] TGT_NONE = 4'hF;

  typedef struct packed {
    logic acc;          // pixel request: add into its column
    logic amb;          // ambient request: latch level, start scan
    logic scan;
    logic mul1;
    logic mul2;
    logic judge;
    logic sweep_start;
    logic sweep;
    logic pass_pick;
    logic load;
  } thcv_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic sweep_done;
  } thcv_sts_t;

endpackage

>>> rtl/core/thcv_in_if.sv
// input channel: one sensor register pair per request
// depends on thcv_pkg for field widths
`timescale 1ns / 1ps

interface thcv_in_if
  import thcv_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [IDX_W-1:0]  pixel_index;
  logic [LOW_W-1:0]  low_byte;
  logic [HIGH_W-1:0] high_byte;

  modport source (output valid, kind, pixel_index, low_byte, high_byte, input ready);
  modport sink   (input valid, kind, pixel_index, low_byte, high_byte, output ready);
endinterface

>>> rtl/core/thcv_out_if.sv
// result channel: pick, vote and peak sum per frame
// depends on thcv_pkg for field widths
`timescale 1ns / 1ps

interface thcv_out_if
  import thcv_pkg::*;
  ;
  logic                     valid;
  logic                     ready;
  logic signed [TGT_W-1:0]  hottest_column;
  logic signed [TGT_W-1:0]  voted_target;
  logic signed [PEAK_W-1:0] peak_sum;

  modport source (output valid, hottest_column, voted_target, peak_sum, input ready);
  modport sink   (input valid, hottest_column, voted_target, peak_sum, output ready);
endinterface

>>> rtl/core/thermal_hot_column_vote_unit.sv
// channel    dir  handshake      payload
// in_ch      in   valid/ready    kind, pixel_index, low_byte, high_byte
// out_ch     out  valid/ready    hottest_column, voted_target, peak_sum
// cfg_*      in   write enable   cfg_index, cfg_wdata
//
// a pixel request is summed as it is accepted; an ambient request runs the
// one-column-per-cycle scan, two chained multiplies and two passes over the
// active window of the target ring memory at one slot per cycle.
// rst_n is synchronous: sums zero, ring reads as no target, config to defaults.
// in_ch is held off while a frame result is computed; a waiting result lets
// pixels through but holds in_ch once the next frame end has been computed.
//
// top level of the hot column vote block; depends on thcv_pkg, the two channel
// interfaces, thcv_ctrl, thcv_dpath and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module thermal_hot_column_vote_unit
  import thcv_pkg::*;
#(
  parameter int COLS       = THCV_COLS,
  parameter int MAX_WINDOW = THCV_MAX_WINDOW
) (
  input  logic                  clk,
  input  logic                  rst_n,
  thcv_in_if.sink               in_ch,
  thcv_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  thcv_cmd_t cmd;
  thcv_sts_t sts;

  thcv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_kind   (in_ch.kind),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  thcv_dpath #(
    .COLS       (COLS),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_pixel_index     (in_ch.pixel_index),
    .in_low_byte        (in_ch.low_byte),
    .in_high_byte       (in_ch.high_byte),
    .cmd                (cmd),
    .sts                (sts),
    .out_hottest_column (out_ch.hottest_column),
    .out_voted_target   (out_ch.voted_target),
    .out_peak_sum       (out_ch.peak_sum)
  );

  // a frame end closes the input until its result is loaded
  `THCV_ASSERT_NEXT(a_amb_blocks_input, clk, rst_n, in_ch.valid && in_ch.ready && in_ch.kind, !in_ch.ready, "input open right after frame end")

  // results are loaded only while the input is held off
  `THCV_ASSERT_SAME(a_load_while_busy, clk, rst_n, $rose(out_ch.valid), $past(!in_ch.ready), "result appeared without a frame end")

  // pixel requests never produce a result
  `THCV_ASSERT_NEXT(a_pixel_no_result, clk, rst_n, in_ch.valid && in_ch.ready && !in_ch.kind && !out_ch.valid, !out_ch.valid, "pixel request produced a result")

  // the pick is a real column or no target
  `THCV_ASSERT_SAME(a_pick_range, clk, rst_n, out_ch.valid, (out_ch.hottest_column == 4'sb1111) || (5'($unsigned(out_ch.hottest_column)) < 5'(COLS)), "pick outside column range")

endmodule

>>> rtl/core/thcv_ctrl.sv
// frame sequencer: idle, column scan, threshold, ring sweeps, result load
// depends on thcv_pkg for command and status structs
`timescale 1ns / 1ps

module thcv_ctrl
  import thcv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_kind,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  input  thcv_sts_t  sts,
  output thcv_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_MUL1  = 3'd2;
  localparam logic [2:0] S_MUL2  = 3'd3;
  localparam logic [2:0] S_JUDGE = 3'd4;
  localparam logic [2:0] S_HIST  = 3'd5;
  localparam logic [2:0] S_PICK  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       load;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  // result register must be free or draining
  assign load      = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    cmd             = '0;
    cmd.acc         = accept && !in_kind;
    cmd.amb         = accept && in_kind;
    cmd.scan        = (state_r == S_SCAN);
    cmd.mul1        = (state_r == S_MUL1);
    cmd.mul2        = (state_r == S_MUL2);
    cmd.judge       = (state_r == S_JUDGE);
    cmd.sweep_start = (state_r == S_JUDGE) || ((state_r == S_HIST) && sts.sweep_done);
    cmd.sweep       = (state_r == S_HIST) || (state_r == S_PICK);
    cmd.pass_pick   = (state_r == S_PICK);
    cmd.load        = load;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept && in_kind) state_nxt = S_SCAN;
      S_SCAN:  if (sts.scan_last) state_nxt = S_MUL1;
      S_MUL1:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_JUDGE;
      S_JUDGE: state_nxt = S_HIST;
      S_HIST:  if (sts.sweep_done) state_nxt = S_PICK;
      S_PICK:  if (sts.sweep_done) state_nxt = S_DONE;
      S_DONE:  if (load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/core/thcv_dpath.sv
// datapath: config registers, column sums, thresholds, target ring and vote
// depends on thcv_pkg; driven by thcv_ctrl commands
`timescale 1ns / 1ps

module thcv_dpath
  import thcv_pkg::*;
#(
  parameter int COLS       = THCV_COLS,
  parameter int MAX_WINDOW = THCV_MAX_WINDOW
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [IDX_W-1:0]         in_pixel_index,
  input  logic [LOW_W-1:0]         in_low_byte,
  input  logic [HIGH_W-1:0]        in_high_byte,
  input  thcv_cmd_t                cmd,
  output thcv_sts_t                sts,
  output logic signed [TGT_W-1:0]  out_hottest_column,
  output logic signed [TGT_W-1:0]  out_voted_target,
  output logic signed [PEAK_W-1:0] out_peak_sum
);

  localparam int CW    = $clog2(COLS);
  localparam int EW    = CW + 1;
  localparam int HW    = $clog2(COLS + 1);
  localparam int NW    = $clog2(MAX_WINDOW + 1);
  localparam int RW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int RHW   = PROD_W + CW + 1;
  localparam int HOTXW = HOT_W + CW;
  localparam int NPIX  = 2 ** IDX_W;
  localparam int LIMIT = COLS * (COLS - 1);

  localparam logic [CW-1:0] COLS_M1   = CW'(COLS - 1);
  localparam logic [EW-1:0] NEG_ENTRY = {1'b1, {CW{1'b0}}};

  // config registers
  logic [WLEN_W-1:0]  window_len_r;
  logic [COEFF_W-1:0] coeff_r;
  logic [HOT_W-1:0]   hot_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= WLEN_RST;
      coeff_r      <= COEFF_RST;
      hot_limit_r  <= HOT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_LEN:  window_len_r <= cfg_wdata[WLEN_W-1:0];
        CFG_AMBIENT_CQ8: coeff_r      <= cfg_wdata[COEFF_W-1:0];
        CFG_HOT_LIMIT:   hot_limit_r  <= cfg_wdata[HOT_W-1:0];
        default: ;
      endcase
    end
  end

  // active window, clamped to 1..MAX_WINDOW
  logic [NW-1:0] wl;
  logic [RW-1:0] wl_m1;

  always_comb begin
    if (window_len_r == '0) begin
      wl = NW'(1);
    end else if ({3'b000, window_len_r} > 8'(MAX_WINDOW)) begin
      wl = NW'(MAX_WINDOW);
    end else begin
      wl = NW'(window_len_r);
    end
  end
  assign wl_m1 = RW'(wl - NW'(1));

  // reading decode and column lookup
  logic signed [RAW_W-1:0] raw;
  logic [CW-1:0]           col_tab [NPIX];
  logic [CW-1:0]           in_col;
  logic                    row_ok;

  assign raw = $signed({in_high_byte, in_low_byte});

  for (genvar g = 0; g < NPIX; g++) begin : g_col
    assign col_tab[g] = CW'(g % COLS);
  end

  assign in_col = col_tab[in_pixel_index];
  // last row and beyond are not summed
  assign row_ok = ({2'b00, in_pixel_index} < 8'(LIMIT));

  // column sums, one shared read port
  logic [SUM_W-1:0] sum_r [COLS];
  logic [CW-1:0]    scan_k_r;
  logic [CW-1:0]    sum_addr;
  logic [SUM_W-1:0] sum_rd;

  assign sum_addr = cmd.scan ? scan_k_r : in_col;
  assign sum_rd   = sum_r[sum_addr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < COLS; i++) sum_r[i] <= '0;
    end else if (cmd.judge) begin
      for (int i = 0; i < COLS; i++) sum_r[i] <= '0;
    end else if (cmd.acc && row_ok) begin
      sum_r[in_col] <= sum_rd + SUM_W'(raw);
    end
  end

  // scan for the first largest column
  logic signed [RAW_W-1:0] ambient_r;
  logic signed [SUM_W-1:0] best_r;
  logic [CW-1:0]           pick_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_k_r <= '0;
    end else if (cmd.amb) begin
      scan_k_r <= '0;
    end else if (cmd.scan) begin
      scan_k_r <= scan_k_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.amb) begin
      ambient_r <= raw;
    end
    if (cmd.scan && ((scan_k_r == '0) || ($signed(sum_rd) > best_r))) begin
      best_r     <= $signed(sum_rd);
      pick_col_r <= scan_k_r;
    end
  end

  assign sts.scan_last = (scan_k_r == COLS_M1);

  // floor and hot limit: floor product in mul1, floor and hot limit products in mul2
  logic signed [PROD_W-1:0] prod1_r;
  logic signed [RHW-1:0]    rhs_r;
  logic [HOTXW-1:0]         hot_r;
  logic signed [RHW-1:0]    best_x;
  logic signed [RHW-1:0]    lhs;
  logic                     reject;
  logic                     pick_rej_r;

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      prod1_r <= PROD_W'($signed({1'b0, coeff_r})) * PROD_W'(ambient_r);
    end
    if (cmd.mul2) begin
      rhs_r <= RHW'(prod1_r) * RHW'($signed({1'b0, COLS_M1}));
      hot_r <= HOTXW'(hot_limit_r) * HOTXW'(COLS_M1);
    end
  end

  assign best_x = RHW'(best_r);
  assign lhs    = best_x <<< 10;
  assign reject = (lhs < rhs_r) || (32'(best_r) > $signed(32'(hot_r)));

  // target ring with valid bits; unwritten slots read as no target
  logic [EW-1:0]         ring_mem [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] ring_vld_r;
  logic [RW-1:0]         wpos_r;
  logic [RW-1:0]         wr_pos;
  logic [NW-1:0]         wp_inc;
  logic [EW-1:0]         new_entry;

  assign wr_pos    = (NW'(wpos_r) >= wl) ? '0 : wpos_r;
  assign wp_inc    = NW'(wr_pos) + NW'(1);
  assign new_entry = reject ? NEG_ENTRY : {1'b0, pick_col_r};

  always_ff @(posedge clk) begin
    if (cmd.judge) begin
      ring_mem[wr_pos] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_vld_r <= '0;
      wpos_r     <= '0;
    end else if (cmd.judge) begin
      ring_vld_r[wr_pos] <= 1'b1;
      wpos_r             <= (wp_inc == wl) ? '0 : RW'(wp_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.judge) begin
      pick_rej_r <= reject;
    end
  end

  // ring sweep: registered read, one slot per cycle
  logic [RW-1:0] idx_r;
  logic          issuing_r;
  logic          rd_vld_r;
  logic          rd_last_r;
  logic [EW-1:0] rd_entry_r;
  logic          rd_ok_r;
  logic [EW-1:0] ent;
  logic [HW-1:0] hidx;

  always_ff @(posedge clk) begin
    rd_entry_r <= ring_mem[idx_r];
    rd_ok_r    <= ring_vld_r[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      issuing_r <= 1'b0;
      rd_vld_r  <= 1'b0;
      rd_last_r <= 1'b0;
    end else begin
      rd_vld_r  <= cmd.sweep && issuing_r && !cmd.sweep_start;
      rd_last_r <= (idx_r == wl_m1);
      if (cmd.sweep_start) begin
        idx_r     <= '0;
        issuing_r <= 1'b1;
      end else if (cmd.sweep && issuing_r) begin
        idx_r <= idx_r + RW'(1);
        if (idx_r == wl_m1) begin
          issuing_r <= 1'b0;
        end
      end
    end
  end

  assign sts.sweep_done = rd_vld_r && rd_last_r;

  assign ent  = rd_ok_r ? rd_entry_r : NEG_ENTRY;
  assign hidx = ent[CW] ? HW'(COLS) : HW'(ent[CW-1:0]);

  // first pass counts each value, second pass takes the first strict maximum
  logic [NW-1:0] hist_r [COLS + 1];
  logic [NW-1:0] cnt;
  logic [NW-1:0] best_cnt_r;
  logic [EW-1:0] voted_r;

  assign cnt = hist_r[hidx];

  always_ff @(posedge clk) begin
    if (cmd.judge) begin
      for (int i = 0; i <= COLS; i++) hist_r[i] <= '0;
      best_cnt_r <= '0;
    end else if (rd_vld_r) begin
      if (!cmd.pass_pick) begin
        hist_r[hidx] <= cnt + NW'(1);
      end else if (cnt > best_cnt_r) begin
        best_cnt_r <= cnt;
        voted_r    <= ent;
      end
    end
  end

  // result register
  logic [TGT_W-1:0]  out_hot_r;
  logic [TGT_W-1:0]  out_vote_r;
  logic [PEAK_W-1:0] out_peak_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_hot_r  <= pick_rej_r ? TGT_NONE : TGT_W'(pick_col_r);
      out_vote_r <= voted_r[CW] ? TGT_NONE : TGT_W'(voted_r[CW-1:0]);
      out_peak_r <= best_r[PEAK_W-1:0];
    end
  end

  assign out_hottest_column = $signed(out_hot_r);
  assign out_voted_target   = $signed(out_vote_r);
  assign out_peak_sum       = $signed(out_peak_r);

endmodule

>>> bench/thermal_hot_column_vote_unit_tb.sv
// testbench for the hot column vote unit: directed frames and random sensor traffic
// checked against an in-bench predictor; depends on thcv_pkg, thcv_in_if and thcv_out_if
`timescale 1ns / 1ps

module thermal_hot_column_vote_unit_tb;
  import thcv_pkg::*;

  localparam int COLS             = THCV_COLS;
  localparam int MAX_WIN          = THCV_MAX_WINDOW;
  localparam int LAST_ROW         = COLS - 1;
  localparam int NUM_PIXELS       = 1 << IDX_W;
  localparam int SETTLE_CYCLES    = 60;
  localparam int SINK_HOLD_CYCLES = 400;
  localparam int STALL_LIMIT      = 4000;
  localparam int RANDOM_ITEMS     = 2000;
  localparam int PHASES           = 8;

  localparam logic KIND_PIXEL   = 1'b0;
  localparam logic KIND_AMBIENT = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  idx;
    logic [LOW_W-1:0]  lo;
    logic [HIGH_W-1:0] hi;
  } sensor_req_t;

  typedef struct {
    logic signed [TGT_W-1:0]  column;
    logic signed [TGT_W-1:0]  vote;
    logic signed [PEAK_W-1:0] peak;
  } frame_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  thcv_in_if  in_ch ();
  thcv_out_if out_ch ();

  thermal_hot_column_vote_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [SUM_W-1:0]        col_sum_q [COLS];
  logic signed [RAW_W-1:0] ambient_q;
  logic signed [TGT_W-1:0] ring_q [MAX_WIN];
  int                      ring_wr_ptr;
  logic [WLEN_W-1:0]       win_len_q;
  logic [COEFF_W-1:0]      coeff_q;
  logic [HOT_W-1:0]        hot_limit_q;

  frame_result_t pending_frames [$];
  frame_result_t want;
  int            mismatch_cnt;
  int            counted_items;
  int            stall_cnt;
  bit            src_idle_on;
  bit            sink_idle_on;
  bit            sink_hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 40))
                                       : int'($urandom_range(1, 3));
  endfunction

  function automatic logic [RAW_W-1:0] rand_pixel_raw();
    case ($urandom_range(0, 9))
      0, 1:    return RAW_W'($urandom);
      2:       return RAW_W'($urandom_range(0, 40));
      default: return RAW_W'($urandom_range(60, 180));
    endcase
  endfunction

  function automatic logic [RAW_W-1:0] rand_ambient_raw();
    if ($urandom_range(0, 9) < 3) return RAW_W'($urandom);
    return RAW_W'($urandom_range(320, 560));
  endfunction

  // mirror of the block: column sums per pixel, pick and ring vote per ambient request
  task automatic apply_request(input sensor_req_t r);
    logic signed [RAW_W-1:0] raw;
    int                      best, pick, voted, best_cnt, cnt, wl, c, i, j;
    longint                  floor_lhs, floor_rhs;
    frame_result_t           res;
    raw = {r.hi, r.lo};
    if (r.kind == KIND_PIXEL) begin
      if (int'(r.idx) / COLS < LAST_ROW)
        col_sum_q[int'(r.idx) % COLS] += {{(SUM_W-RAW_W){raw[RAW_W-1]}}, raw};
    end else begin
      ambient_q = raw;
      pick = 0;
      best = int'($signed(col_sum_q[0]));
      for (c = 1; c < COLS; c++) begin
        if (int'($signed(col_sum_q[c])) > best) begin
          best = int'($signed(col_sum_q[c]));
          pick = c;
        end
      end
      floor_lhs = longint'(best) * 1024;
      floor_rhs = longint'(coeff_q) * longint'(ambient_q) * LAST_ROW;
      if (floor_lhs < floor_rhs || longint'(best) > longint'(hot_limit_q) * LAST_ROW)
        pick = -1;

      wl = (win_len_q == 0) ? 1 : ((int'(win_len_q) > MAX_WIN) ? MAX_WIN : int'(win_len_q));
      // a shrunken window can leave the pointer past its end
      if (ring_wr_ptr >= wl) ring_wr_ptr = 0;
      ring_q[ring_wr_ptr] = TGT_W'(pick);
      ring_wr_ptr = (ring_wr_ptr + 1) % wl;

      voted = int'(ring_q[0]);
      best_cnt = 0;
      for (i = 0; i < wl; i++) begin
        cnt = 0;
        for (j = 0; j < wl; j++)
          if (ring_q[j] == ring_q[i]) cnt++;
        if (cnt > best_cnt) begin
          best_cnt = cnt;
          voted = int'(ring_q[i]);
        end
      end

      res.column = TGT_W'(pick);
      res.vote   = TGT_W'(voted);
      res.peak   = PEAK_W'(best);
      pending_frames.push_back(res);
      for (c = 0; c < COLS; c++) col_sum_q[c] = '0;
    end
  endtask

  // called and returns at a falling edge
  task automatic send_request(input sensor_req_t r);
    in_ch.kind        = r.kind;
    in_ch.pixel_index = r.idx;
    in_ch.low_byte    = r.lo;
    in_ch.high_byte   = r.hi;
    in_ch.valid       = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    apply_request(r);
    counted_items++;
    @(negedge clk);
    in_ch.valid = 1'b0;
    if (src_idle_on && $urandom_range(0, 3) == 0) repeat (pick_gap()) @(negedge clk);
  endtask

  task automatic send_pixel(input int idx, input logic [RAW_W-1:0] raw);
    send_request('{kind: KIND_PIXEL, idx: IDX_W'(idx), lo: raw[7:0], hi: raw[11:8]});
  endtask

  task automatic send_ambient(input logic [RAW_W-1:0] raw);
    send_request('{kind: KIND_AMBIENT, idx: '0, lo: raw[7:0], hi: raw[11:8]});
  endtask

  // wait out every pending frame plus the tail of any pixel still in flight
  task automatic settle_frames();
    while (pending_frames.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    case (idx)
      CFG_WINDOW_LEN:  win_len_q   = data[WLEN_W-1:0];
      CFG_AMBIENT_CQ8: coeff_q     = data[COEFF_W-1:0];
      CFG_HOT_LIMIT:   hot_limit_q = data[HOT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_config(input int wlen, input int coeff, input int hot);
    write_reg(CFG_WINDOW_LEN, CFG_DATA_W'(wlen));
    write_reg(CFG_AMBIENT_CQ8, CFG_DATA_W'(coeff));
    write_reg(CFG_HOT_LIMIT, CFG_DATA_W'(hot));
  endtask

  task automatic random_frame();
    int style, hot_col, base, boost, n, idx;
    bit neg;
    style = $urandom_range(0, 19);
    if (style < 7) begin
      // whole array in order, one column pushed up; boost 0 gives exact ties
      hot_col = $urandom_range(0, COLS - 1);
      base    = $urandom_range(40, 200);
      boost   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      for (idx = 0; idx < NUM_PIXELS; idx++)
        send_pixel(idx, RAW_W'(base + ((idx % COLS == hot_col) ? boost : 0)
                               + ((boost == 0) ? 0 : $urandom_range(0, 8))));
    end else if (style < 14) begin
      n = $urandom_range(0, 24);
      repeat (n) send_pixel($urandom_range(0, NUM_PIXELS - 1), rand_pixel_raw());
    end else if (style < 18) begin
      n = $urandom_range(0, 70);
      repeat (n) send_pixel($urandom_range(0, NUM_PIXELS - 1), RAW_W'($urandom));
    end else begin
      // hammer one counted pixel with extreme readings so its column sum wraps
      idx = $urandom_range(0, COLS * LAST_ROW - 1);
      neg = 1'($urandom_range(0, 1));
      n   = $urandom_range(17, 40);
      repeat (n)
        send_pixel(idx, neg ? RAW_W'($urandom_range(12'h800, 12'h80F))
                            : RAW_W'($urandom_range(12'h7F0, 12'h7FF)));
    end
    send_ambient(rand_ambient_raw());
  endtask

  task automatic test_field_extremes();
    send_pixel(0, 12'h7FF);
    send_pixel(1, 12'h800);
    send_pixel(NUM_PIXELS - 1, 12'h7FF);  // last row, not counted
    send_pixel(COLS * LAST_ROW, 12'h123);
    send_ambient(12'h800);
  endtask

  task automatic test_threshold_edges();
    send_pixel(5, 12'd1120);  // exactly at the hot limit
    send_ambient(12'd0);
    send_pixel(5, 12'd1121);
    send_ambient(12'd0);
    send_pixel(0, 12'd7);     // exactly on the ambient floor
    send_ambient(12'd4);
    send_pixel(0, 12'd6);
    send_ambient(12'd4);
  endtask

  task automatic test_window_edges();
    // empty frames: ambient 0 picks column 0, ambient 1 falls below the floor
    settle_frames();
    write_reg(CFG_WINDOW_LEN, 16'd0);
    send_ambient(12'd0);
    send_ambient(12'd1);
    settle_frames();
    write_reg(CFG_WINDOW_LEN, 16'd31);
    repeat (3) send_ambient(12'd0);
    settle_frames();
    write_reg(CFG_WINDOW_LEN, 16'd2);
    send_ambient(12'd1);
    send_ambient(12'd0);
    send_ambient(12'd0);
  endtask

  task automatic test_unused_index();
    settle_frames();
    write_reg(CFG_UNUSED, 16'hFFFF);
    send_ambient(12'd0);
  endtask

  task automatic test_sink_backpressure();
    settle_frames();
    src_idle_on   = 1'b0;
    sink_hold_req = 1'b1;
    repeat (4) begin
      repeat (10) send_pixel($urandom_range(0, COLS * LAST_ROW - 1), rand_pixel_raw());
      send_ambient(rand_ambient_raw());
    end
    src_idle_on = 1'b1;
  endtask

  task automatic test_source_pause();
    repeat (3) begin
      random_frame();
      settle_frames();
    end
  endtask

  task automatic test_random_traffic();
    int ph, target;
    for (ph = 0; ph < PHASES; ph++) begin
      settle_frames();
      case (ph)
        0: set_config(5, 256, 160);
        1: set_config(1, 0, 2047);
        2: set_config(16, 65535, 0);
        3: set_config(0, 300, 200);
        4: set_config(31, 128, 100);
        default:
          set_config($urandom_range(0, 31),
                     ($urandom_range(0, 1) == 0) ? $urandom_range(200, 320)
                                                 : $urandom_range(0, 65535),
                     $urandom_range(0, 2047));
      endcase
      src_idle_on  = (ph % 3 != 1);
      sink_idle_on = (ph % 3 != 2);
      target = counted_items + RANDOM_ITEMS / PHASES;
      while (counted_items < target) random_frame();
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // result sink: random stalls, plus one long hold on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        out_ch.ready  = 1'b0;
        repeat (SINK_HOLD_CYCLES) @(negedge clk);
      end else if (sink_idle_on && rst_n && $urandom_range(0, 3) == 0) begin
        out_ch.ready = 1'b0;
        repeat (pick_gap()) @(negedge clk);
      end
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_frames.size() == 0) begin
        $error("unexpected result: hottest_column %0d voted_target %0d peak_sum %0d",
               out_ch.hottest_column, out_ch.voted_target, out_ch.peak_sum);
        mismatch_cnt++;
      end else begin
        want = pending_frames.pop_front();
        if (out_ch.hottest_column !== want.column) begin
          $error("hottest_column: expected %0d, got %0d", want.column, out_ch.hottest_column);
          mismatch_cnt++;
        end
        if (out_ch.voted_target !== want.vote) begin
          $error("voted_target: expected %0d, got %0d", want.vote, out_ch.voted_target);
          mismatch_cnt++;
        end
        if (out_ch.peak_sum !== want.peak) begin
          $error("peak_sum: expected %0d, got %0d", want.peak, out_ch.peak_sum);
          mismatch_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no request moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cnt = 0;
    else
      stall_cnt++;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_PIXEL;
    in_ch.pixel_index = '0;
    in_ch.low_byte    = '0;
    in_ch.high_byte   = '0;
    mismatch_cnt      = 0;
    counted_items     = 0;
    stall_cnt         = 0;
    src_idle_on       = 1'b1;
    sink_idle_on      = 1'b1;
    sink_hold_req     = 1'b0;
    win_len_q         = WLEN_RST;
    coeff_q           = COEFF_RST;
    hot_limit_q       = HOT_RST;
    ambient_q         = '0;
    ring_wr_ptr       = 0;
    foreach (col_sum_q[c]) col_sum_q[c] = '0;
    foreach (ring_q[k]) ring_q[k] = TGT_NONE;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_field_extremes();
    test_threshold_edges();
    test_window_edges();
    test_unused_index();
    test_sink_backpressure();
    test_source_pause();
    test_random_traffic();

    while (pending_frames.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
